// ----- src/pecd_pkg.sv -----
// shared types and constants for the printer escape command decoder
package pecd_pkg;

	// received control characters
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_HT  = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SUB = 8'h1A;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_SP  = 8'h20;

	// attribute masks
	localparam logic [2:0] ATTR_BOLD      = 3'b001;
	localparam logic [2:0] ATTR_UNDERLINE = 3'b010;
	localparam logic [2:0] ATTR_BROKEN    = 3'b100;

	// pitch settings: microspaces, microlines, tab spacing
	localparam logic [7:0] PITCH_P_US = 8'd12;
	localparam logic [4:0] PITCH_P_UL = 5'd16;
	localparam logic [2:0] PITCH_P_TS = 3'd5;
	localparam logic [7:0] PITCH_E_US = 8'd10;
	localparam logic [4:0] PITCH_E_UL = 5'd16;
	localparam logic [2:0] PITCH_E_TS = 3'd6;
	localparam logic [7:0] PITCH_M_US = 8'd8;
	localparam logic [4:0] PITCH_M_UL = 5'd12;
	localparam logic [2:0] PITCH_M_TS = 3'd7;

	// reset values of the carriage state
	localparam logic [7:0] COLUMN_HOME = 8'd1;
	localparam logic [2:0] TAB_RESET   = 3'd5;

	// mechanism commands
	typedef enum logic [3:0] {
		CMD_SPIN      = 4'd0,
		CMD_BS        = 4'd1,
		CMD_HTAB      = 4'd2,
		CMD_LF        = 4'd3,
		CMD_CR        = 4'd4,
		CMD_LETTER    = 4'd5,
		CMD_HALFUP    = 4'd6,
		CMD_HALFDOWN  = 4'd7,
		CMD_REVLF     = 4'd8,
		CMD_MICROBS   = 4'd9,
		CMD_MICROUP   = 4'd10,
		CMD_MICRODOWN = 4'd11,
		CMD_PITCH     = 4'd12,
		CMD_RESET     = 4'd13,
		CMD_ERRLED    = 4'd14
	} cmd_t;

	// escape sequence phases
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ESC  = 3'd1,
		PH_SUB  = 3'd2,
		PH_SUBP = 3'd3,
		PH_SUBE = 3'd4,
		PH_HOLD = 3'd6
	} phase_t;

	// classified operations handed from front to back
	typedef enum logic [3:0] {
		OP_EMIT,
		OP_BS,
		OP_HT,
		OP_CR,
		OP_LETTER,
		OP_ATTR_OR,
		OP_ATTR_AND,
		OP_PITCH_P,
		OP_PITCH_E,
		OP_PITCH_M,
		OP_ERRLED
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		cmd_t       cmd;
		logic [7:0] data;
	} op_t;

	// back end states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_HT,
		BK_LF
	} back_state_t;

	// one result word
	typedef struct packed {
		cmd_t       command;
		logic [7:0] argument;
		logic [2:0] attribute_bits;
		logic [4:0] lines_per_line;
		logic [7:0] column_now;
		logic       last;
	} res_t;

endpackage

// ----- src/printer_escape_command_decoder.sv -----
// top level of the printer escape command decoder
// a byte enters the op queue at its accepting edge; the back end then queues its first result word
// most bytes sustain 1 per cycle while neither queue is full; CR with auto linefeed also yields an LF word
// HT holds the back end while the bit-serial remainder unit runs (one column bit per cycle)
// arst_n clears escape phase, queues and config; column 1, tab spacing 5, attributes 0
module printer_escape_command_decoder #(
	parameter int OP_DEPTH  = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] command,
	output logic [7:0] argument,
	output logic [2:0] attribute_bits,
	output logic [4:0] lines_per_line,
	output logic [7:0] column_now,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	import pecd_pkg::*;

	logic take;
	logic op_push;
	logic op_full;
	logic op_pop;
	logic op_empty;
	op_t  op_in;
	op_t  op_out;
	logic res_push;
	logic res_full;
	res_t res_in;
	res_t res_out;

	// input word handshake
	assign full      = op_full;
	assign take      = push && !op_full;
	assign cfg_ready = 1'b1;

	pecd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.char_in (char_in),
		.op_push (op_push),
		.op      (op_in)
	);

	pecd_queue #(
		.WIDTH ($bits(op_t)),
		.DEPTH (OP_DEPTH)
	) u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.full   (op_full),
		.wdata  (op_in),
		.pop    (op_pop),
		.empty  (op_empty),
		.rdata  (op_out)
	);

	pecd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_bit  (cfg_data),
		.op_empty (op_empty),
		.op       (op_out),
		.op_pop   (op_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	pecd_queue #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_in),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_out)
	);

	// result word fields
	assign command        = res_out.command;
	assign argument       = res_out.argument;
	assign attribute_bits = res_out.attribute_bits;
	assign lines_per_line = res_out.lines_per_line;
	assign column_now     = res_out.column_now;
	assign last           = res_out.last;

	// back end never takes an op that is not there
	a_op_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> !op_empty)
		else $error("op popped from empty queue");

	// back end never writes a result into a full queue
	a_res_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	// tab distance is between one and the largest tab spacing
	a_htab_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_in.command == CMD_HTAB) |->
		(res_in.argument != 8'd0 && res_in.argument <= 8'd7))
		else $error("tab distance out of range");

	// a carriage return without its final mark is followed by a linefeed
	a_cr_then_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res_full && res_in.command == CMD_CR && !res_in.last) |=>
		(!res_push || res_in.command == CMD_LF))
		else $error("auto linefeed missing after carriage return");

endmodule

// ----- src/pecd_queue.sv -----
// small register queue used between the decoder parts and at the output
module pecd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	// status and handshakes
	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= wdata;
		end
	end

endmodule

// ----- src/pecd_front.sv -----
// front end: escape sequence tracking and byte classification
module pecd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    char_in,
	output logic          op_push,
	output pecd_pkg::op_t op
);
	import pecd_pkg::*;

	phase_t phase_q;
	phase_t phase_n;
	logic   op_valid;

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (take) begin
			phase_q <= phase_n;
		end
	end

	// classify the byte against the current phase
	always_comb begin
		phase_n  = phase_q;
		op_valid = 1'b0;
		op.kind  = OP_EMIT;
		op.cmd   = CMD_SPIN;
		op.data  = char_in;
		case (phase_q)
			PH_IDLE: begin
				case (char_in)
					CH_NUL: ;
					CH_BEL: begin
						op_valid = 1'b1;
						op.cmd   = CMD_SPIN;
					end
					CH_BS: begin
						op_valid = 1'b1;
						op.kind  = OP_BS;
					end
					CH_HT: begin
						op_valid = 1'b1;
						op.kind  = OP_HT;
					end
					CH_LF, CH_VT: begin
						op_valid = 1'b1;
						op.cmd   = CMD_LF;
					end
					CH_CR: begin
						op_valid = 1'b1;
						op.kind  = OP_CR;
					end
					CH_ESC: phase_n = PH_ESC;
					default: begin
						op_valid = 1'b1;
						op.kind  = OP_LETTER;
					end
				endcase
			end
			PH_ESC: begin
				phase_n  = PH_IDLE;
				op_valid = 1'b1;
				case (char_in)
					"O": begin
						op.kind = OP_ATTR_OR;
						op.data = {5'b0, ATTR_BOLD};
					end
					"E": begin
						op.kind = OP_ATTR_OR;
						op.data = {5'b0, ATTR_UNDERLINE};
					end
					"b": begin
						op.kind = OP_ATTR_OR;
						op.data = {5'b0, ATTR_BROKEN};
					end
					"&": begin
						op.kind = OP_ATTR_AND;
						op.data = {5'b0, ATTR_UNDERLINE | ATTR_BROKEN};
					end
					"R": begin
						op.kind = OP_ATTR_AND;
						op.data = {5'b0, ATTR_BOLD};
					end
					"X": begin
						op.kind = OP_ATTR_AND;
						op.data = 8'd0;
					end
					"U":    op.cmd = CMD_HALFUP;
					"D":    op.cmd = CMD_HALFDOWN;
					CH_LF:  op.cmd = CMD_REVLF;
					CH_BS:  op.cmd = CMD_MICROBS;
					"u":    op.cmd = CMD_MICROUP;
					"d":    op.cmd = CMD_MICRODOWN;
					"p":    op.kind = OP_PITCH_P;
					"e":    op.kind = OP_PITCH_E;
					"m":    op.kind = OP_PITCH_M;
					CH_SUB: begin
						op_valid = 1'b0;
						phase_n  = PH_SUB;
					end
					"H", "h": begin
						op_valid = 1'b0;
						phase_n  = PH_HOLD;
					end
					default: begin
						op_valid = 1'b0;
						phase_n  = PH_ESC;
					end
				endcase
			end
			PH_SUB: begin
				case (char_in)
					"c", "s", "u", "w": phase_n = PH_IDLE;
					"e": phase_n = PH_SUBE;
					"p": phase_n = PH_SUBP;
					"r": begin
						phase_n  = PH_IDLE;
						op_valid = 1'b1;
						op.cmd   = CMD_RESET;
					end
					default: ;
				endcase
			end
			PH_SUBP: begin
				if (char_in >= "0" && char_in <= "3") begin
					phase_n = PH_IDLE;
				end
			end
			PH_SUBE: begin
				phase_n  = PH_IDLE;
				op_valid = 1'b1;
				op.kind  = OP_ERRLED;
				op.data  = {7'b0, char_in[0]};
			end
			PH_HOLD: begin
				if (char_in == CH_SP || char_in == CH_ESC) begin
					phase_n = PH_IDLE;
				end
			end
			default: phase_n = PH_IDLE;
		endcase
	end

	assign op_push = take && op_valid;

endmodule

// ----- src/pecd_back.sv -----
// back end: carriage state, tab remainder unit and result generation
module pecd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_bit,
	input  logic           op_empty,
	input  pecd_pkg::op_t  op,
	output logic           op_pop,
	input  logic           res_full,
	output logic           res_push,
	output pecd_pkg::res_t res
);
	import pecd_pkg::*;

	back_state_t state_q;
	back_state_t state_n;
	logic        auto_lf_q;
	logic [7:0]  column_q;
	logic [7:0]  column_n;
	logic [2:0]  attr_q;
	logic [2:0]  attr_n;
	logic [2:0]  tab_q;
	logic [2:0]  tab_n;
	logic [7:0]  div_col_q;
	logic [2:0]  rem_q;
	logic [2:0]  cnt_q;
	logic [2:0]  ts_eff;
	logic [3:0]  trial;
	logic [2:0]  rem_step;
	logic [2:0]  tab_dist;
	logic        div_start;

	// tab spacing of zero counts as one
	assign ts_eff   = (tab_q == 3'd0) ? 3'd1 : tab_q;
	// one restoring remainder step per cycle, msb first
	assign trial    = {rem_q, div_col_q[7]};
	assign rem_step = (trial >= {1'b0, ts_eff}) ? 3'(trial - {1'b0, ts_eff}) : trial[2:0];
	assign tab_dist = ts_eff - rem_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_lf_q <= 1'b0;
		end else if (cfg_we) begin
			auto_lf_q <= cfg_bit;
		end
	end

	// state and carriage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			column_q <= COLUMN_HOME;
			attr_q   <= '0;
			tab_q    <= TAB_RESET;
		end else begin
			state_q  <= state_n;
			column_q <= column_n;
			attr_q   <= attr_n;
			tab_q    <= tab_n;
		end
	end

	// remainder unit registers
	always_ff @(posedge clk) begin
		if (div_start) begin
			div_col_q <= column_q;
			rem_q     <= '0;
			cnt_q     <= 3'd7;
		end else if (state_q == BK_DIV) begin
			div_col_q <= {div_col_q[6:0], 1'b0};
			rem_q     <= rem_step;
			cnt_q     <= cnt_q - 1'b1;
		end
	end

	// operation sequencing and result build
	always_comb begin
		state_n            = state_q;
		column_n           = column_q;
		attr_n             = attr_q;
		tab_n              = tab_q;
		op_pop             = 1'b0;
		res_push           = 1'b0;
		div_start          = 1'b0;
		res.command        = op.cmd;
		res.argument       = 8'd0;
		res.attribute_bits = attr_q;
		res.lines_per_line = 5'd0;
		res.column_now     = column_q;
		res.last           = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (!op_empty) begin
					case (op.kind)
						OP_ATTR_OR: begin
							op_pop = 1'b1;
							attr_n = attr_q | op.data[2:0];
						end
						OP_ATTR_AND: begin
							op_pop = 1'b1;
							attr_n = attr_q & op.data[2:0];
						end
						OP_HT: begin
							op_pop    = 1'b1;
							div_start = 1'b1;
							state_n   = BK_DIV;
						end
						OP_BS: begin
							if (column_q <= 8'd1) begin
								op_pop = 1'b1;
							end else if (!res_full) begin
								op_pop         = 1'b1;
								res_push       = 1'b1;
								column_n       = column_q - 1'b1;
								res.command    = CMD_BS;
								res.column_now = column_n;
							end
						end
						OP_LETTER: begin
							if (!res_full) begin
								op_pop         = 1'b1;
								res_push       = 1'b1;
								column_n       = column_q + 1'b1;
								res.command    = CMD_LETTER;
								res.argument   = op.data;
								res.column_now = column_n;
							end
						end
						OP_CR: begin
							if (!res_full) begin
								op_pop             = 1'b1;
								res_push           = 1'b1;
								column_n           = COLUMN_HOME;
								attr_n             = '0;
								res.command        = CMD_CR;
								res.attribute_bits = '0;
								res.column_now     = COLUMN_HOME;
								res.last           = !auto_lf_q;
								if (auto_lf_q) begin
									state_n = BK_LF;
								end
							end
						end
						OP_PITCH_P, OP_PITCH_E, OP_PITCH_M: begin
							if (!res_full) begin
								op_pop      = 1'b1;
								res_push    = 1'b1;
								res.command = CMD_PITCH;
								if (op.kind == OP_PITCH_P) begin
									tab_n              = PITCH_P_TS;
									res.argument       = PITCH_P_US;
									res.lines_per_line = PITCH_P_UL;
								end else if (op.kind == OP_PITCH_E) begin
									tab_n              = PITCH_E_TS;
									res.argument       = PITCH_E_US;
									res.lines_per_line = PITCH_E_UL;
								end else begin
									tab_n              = PITCH_M_TS;
									res.argument       = PITCH_M_US;
									res.lines_per_line = PITCH_M_UL;
								end
							end
						end
						OP_ERRLED: begin
							if (!res_full) begin
								op_pop       = 1'b1;
								res_push     = 1'b1;
								res.command  = CMD_ERRLED;
								res.argument = {7'b0, op.data[0]};
							end
						end
						default: begin
							if (!res_full) begin
								op_pop   = 1'b1;
								res_push = 1'b1;
							end
						end
					endcase
				end
			end
			BK_DIV: begin
				if (cnt_q == 3'd0) begin
					state_n = BK_HT;
				end
			end
			BK_HT: begin
				if (!res_full) begin
					res_push       = 1'b1;
					column_n       = column_q + {5'b0, tab_dist};
					res.command    = CMD_HTAB;
					res.argument   = {5'b0, tab_dist};
					res.column_now = column_n;
					state_n        = BK_IDLE;
				end
			end
			BK_LF: begin
				if (!res_full) begin
					res_push    = 1'b1;
					res.command = CMD_LF;
					state_n     = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

endmodule
